// File: src/bmp_pkg.sv
// Shared types and constants of the BLE-MIDI packet parser.
`default_nettype none
package bmp_pkg;

    // Result kinds
    localparam logic [3:0] KIND_NOTE_OFF = 4'd0;
    localparam logic [3:0] KIND_STOP     = 4'd7;
    localparam logic [3:0] KIND_ERROR    = 4'd8;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_HEADER = 2'd1;
    localparam logic [1:0] ERR_SHORT      = 2'd2;
    localparam logic [1:0] ERR_NO_STATUS  = 2'd3;

    // Status nibbles and bytes that need special handling
    localparam logic [3:0] CMD_PROGRAM  = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRS = 4'hD;
    localparam logic [3:0] CMD_BEND     = 4'hE;
    localparam logic [3:0] CMD_SYSTEM   = 4'hF;
    localparam logic [7:0] STATUS_STOP  = 8'hFC;
    localparam logic [3:0] STOP_CHANNEL = 4'hC;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_TS1      = 7'b0000010,
        PH_LOOP     = 7'b0000100,
        PH_AFTER_TS = 7'b0001000,
        PH_NEED_D1  = 7'b0010000,
        PH_NEED_D2  = 7'b0100000,
        PH_SKIP     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_first;
        logic       packet_last;
    } t_beat;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [3:0]  midi_channel;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [13:0] bend_value;
        logic [12:0] time_stamp;
        logic [1:0]  error_code;
    } t_result;

endpackage
`default_nettype wire

// File: src/bmp_in_reg.sv
// Input register that holds one accepted byte beat until the parser takes it.
`default_nettype none
module bmp_in_reg (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  bmp_pkg::t_beat i_beat,
    input  wire            i_take,
    output logic           o_in_stall,
    output logic           o_beat_valid,
    output bmp_pkg::t_beat o_beat
);

    logic           r_valid;
    bmp_pkg::t_beat r_beat;

    // The register is free when empty or when its beat is consumed this cycle.
    assign o_in_stall   = r_valid && !i_take;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_beat <= i_beat;
        end
    end

endmodule
`default_nettype wire

// File: src/bmp_parse.sv
// Packet parse state and the single-pass logic that decodes one byte.
`default_nettype none
module bmp_parse (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_wr_en,
    input  wire  [7:0]       i_cfg_wr_data,
    input  wire              i_step,
    input  bmp_pkg::t_beat   i_beat,
    output logic             o_res_valid,
    output bmp_pkg::t_result o_res
);

    bmp_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_status, n_status;
    logic [12:0]      r_stamp, n_stamp;
    logic [7:0]       r_held, n_held;
    logic [7:0]       r_mask;

    logic             cand_en;
    bmp_pkg::t_result cand;
    logic [7:0]       b;
    logic [3:0]       cmd;
    logic             at_start;
    logic             after_ts;

    assign b   = i_beat.packet_byte;
    assign cmd = r_status[7:4];

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_stamp  = r_stamp;
        n_held   = r_held;
        cand_en  = 1'b0;
        cand     = '0;
        at_start = 1'b0;
        after_ts = 1'b0;

        if (i_beat.packet_first) begin
            n_status = '0;
            n_held   = b;
            n_stamp  = {b[5:0], 7'd0};
            n_phase  = bmp_pkg::PH_TS1;
            if (i_beat.packet_last) begin
                cand_en         = 1'b1;
                cand.event_kind = bmp_pkg::KIND_ERROR;
                cand.error_code = bmp_pkg::ERR_SHORT;
                n_phase         = bmp_pkg::PH_IDLE;
            end
        end else begin
            unique case (r_phase)
                bmp_pkg::PH_TS1: begin
                    if (i_beat.packet_last) begin
                        cand_en         = 1'b1;
                        cand.event_kind = bmp_pkg::KIND_ERROR;
                        cand.error_code = bmp_pkg::ERR_SHORT;
                        n_phase         = bmp_pkg::PH_SKIP;
                    end else if (!r_held[7] || !b[7]) begin
                        cand_en         = 1'b1;
                        cand.event_kind = bmp_pkg::KIND_ERROR;
                        cand.error_code = bmp_pkg::ERR_BAD_HEADER;
                        n_phase         = bmp_pkg::PH_SKIP;
                    end else begin
                        n_stamp = {r_stamp[12:7], b[6:0]};
                        n_phase = bmp_pkg::PH_AFTER_TS;
                    end
                end
                bmp_pkg::PH_LOOP: begin
                    if (b[7]) begin
                        n_stamp = {r_stamp[12:7], b[6:0]};
                        n_phase = bmp_pkg::PH_AFTER_TS;
                    end else begin
                        at_start = 1'b1;
                    end
                end
                bmp_pkg::PH_AFTER_TS: begin
                    if (b[7]) begin
                        n_status = b;
                        if (b[7:4] == bmp_pkg::CMD_SYSTEM) begin
                            n_phase = bmp_pkg::PH_LOOP;
                            if (b == bmp_pkg::STATUS_STOP) begin
                                cand_en           = 1'b1;
                                cand.event_kind   = bmp_pkg::KIND_STOP;
                                cand.midi_channel = bmp_pkg::STOP_CHANNEL;
                                cand.time_stamp   = r_stamp;
                            end
                        end else begin
                            n_phase = bmp_pkg::PH_NEED_D1;
                        end
                    end else begin
                        at_start = 1'b1;
                        after_ts = 1'b1;
                    end
                end
                bmp_pkg::PH_NEED_D1: begin
                    if (cmd == bmp_pkg::CMD_PROGRAM || cmd == bmp_pkg::CMD_CHAN_PRS) begin
                        n_phase           = bmp_pkg::PH_LOOP;
                        cand_en           = 1'b1;
                        cand.event_kind   = {1'b0, cmd[2:0]};
                        cand.midi_channel = r_status[3:0];
                        cand.data_first   = b;
                        cand.time_stamp   = r_stamp;
                    end else begin
                        n_held  = b;
                        n_phase = bmp_pkg::PH_NEED_D2;
                    end
                end
                bmp_pkg::PH_NEED_D2: begin
                    n_phase           = bmp_pkg::PH_LOOP;
                    cand_en           = cmd[3];
                    cand.event_kind   = {1'b0, cmd[2:0]};
                    cand.midi_channel = r_status[3:0];
                    cand.data_first   = r_held;
                    cand.data_second  = b;
                    cand.time_stamp   = r_stamp;
                    if (cmd == bmp_pkg::CMD_BEND) begin
                        cand.bend_value = {b[6:0], r_held[6:0]};
                    end
                end
                bmp_pkg::PH_IDLE, bmp_pkg::PH_SKIP: begin
                end
                default: begin
                end
            endcase

            // A data byte where a message begins runs under the running status.
            if (at_start) begin
                if (!cmd[3]) begin
                    cand_en         = 1'b1;
                    cand.event_kind = bmp_pkg::KIND_ERROR;
                    cand.error_code = bmp_pkg::ERR_NO_STATUS;
                    n_phase         = bmp_pkg::PH_SKIP;
                end else if (cmd == bmp_pkg::CMD_SYSTEM) begin
                    n_phase = bmp_pkg::PH_LOOP;
                    if (after_ts && r_status == bmp_pkg::STATUS_STOP) begin
                        cand_en           = 1'b1;
                        cand.event_kind   = bmp_pkg::KIND_STOP;
                        cand.midi_channel = bmp_pkg::STOP_CHANNEL;
                        cand.time_stamp   = r_stamp;
                    end
                end else if (cmd == bmp_pkg::CMD_PROGRAM ||
                             cmd == bmp_pkg::CMD_CHAN_PRS) begin
                    n_phase           = bmp_pkg::PH_LOOP;
                    cand_en           = 1'b1;
                    cand.event_kind   = {1'b0, cmd[2:0]};
                    cand.midi_channel = r_status[3:0];
                    cand.data_first   = b;
                    cand.time_stamp   = r_stamp;
                end else begin
                    n_held  = b;
                    n_phase = bmp_pkg::PH_NEED_D2;
                end
            end

            if (r_phase != bmp_pkg::PH_IDLE && i_beat.packet_last) begin
                n_phase = bmp_pkg::PH_IDLE;
            end
        end
    end

    // Errors are always reported; every other kind is gated by its mask bit.
    always_comb begin
        o_res       = cand;
        o_res_valid = 1'b0;
        if (i_step && cand_en) begin
            o_res_valid = (cand.event_kind == bmp_pkg::KIND_ERROR) ||
                          r_mask[cand.event_kind[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bmp_pkg::PH_IDLE;
            r_status <= '0;
            r_stamp  <= '0;
            r_held   <= '0;
            r_mask   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_phase  <= n_phase;
                r_status <= n_status;
                r_stamp  <= n_stamp;
                r_held   <= n_held;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/bmp_out_reg.sv
// Result register that holds a decoded event until the receiver takes it.
`default_nettype none
module bmp_out_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_res_valid,
    input  bmp_pkg::t_result i_res,
    input  wire              i_out_stall,
    output logic             o_free,
    output logic             o_out_valid,
    output bmp_pkg::t_result o_res
);

    logic             r_valid;
    bmp_pkg::t_result r_res;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// File: src/ble_midi_packet_parser_unit.sv
// BLE-MIDI packet parser: takes packet bytes and gives decoded MIDI events.
// Input channel: one packet byte per beat with first and last marks, taken
// when i_in_valid is high and o_in_stall is low. Output channel: at most one
// event per input byte, given when o_out_valid is high and i_out_stall low.
// Each byte passes an input register, the combinational decode logic and a
// result register, in that order.
// Throughput is one byte per cycle while i_out_stall is low; the decode step,
// which updates the packet state for each byte in one pass, sets that figure.
// Bytes that give no event (headers, timestamps, first data bytes, masked
// kinds) simply leave nothing in the result register.
// While the receiver stalls, the result register holds its event and the
// input register holds the next byte; o_in_stall rises only when both are
// full. The event mask is written through i_cfg_wr_en and i_cfg_wr_data;
// the user must write it only while the block is idle; no check enforces it.
// The synchronous active-low reset clears the parse state, the mask and
// both valid flags; the block accepts input as soon as reset is released.
`default_nettype none
module ble_midi_packet_parser_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_packet_byte,
    input  wire         i_packet_first,
    input  wire         i_packet_last,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [3:0]  o_event_kind,
    output logic [3:0]  o_midi_channel,
    output logic [7:0]  o_data_first,
    output logic [7:0]  o_data_second,
    output logic [13:0] o_bend_value,
    output logic [12:0] o_time_stamp,
    output logic [1:0]  o_error_code
);

    bmp_pkg::t_beat   in_beat;
    bmp_pkg::t_beat   held_beat;
    logic             held_valid;
    logic             out_free;
    logic             step;
    logic             res_valid;
    bmp_pkg::t_result res;
    bmp_pkg::t_result out_res;

    assign in_beat.packet_byte  = i_packet_byte;
    assign in_beat.packet_first = i_packet_first;
    assign in_beat.packet_last  = i_packet_last;

    assign step = held_valid && out_free;

    bmp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_beat      (in_beat),
        .i_take      (out_free),
        .o_in_stall  (o_in_stall),
        .o_beat_valid(held_valid),
        .o_beat      (held_beat)
    );

    bmp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_step       (step),
        .i_beat       (held_beat),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    bmp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_valid(res_valid),
        .i_res      (res),
        .i_out_stall(i_out_stall),
        .o_free     (out_free),
        .o_out_valid(o_out_valid),
        .o_res      (out_res)
    );

    assign o_event_kind   = out_res.event_kind;
    assign o_midi_channel = out_res.midi_channel;
    assign o_data_first   = out_res.data_first;
    assign o_data_second  = out_res.data_second;
    assign o_bend_value   = out_res.bend_value;
    assign o_time_stamp   = out_res.time_stamp;
    assign o_error_code   = out_res.error_code;

endmodule
`default_nettype wire

// File: test/ble_midi_packet_parser_unit_test.sv
// Self-checking testbench for the BLE-MIDI packet parser unit.
`timescale 1ns / 100ps
module ble_midi_packet_parser_unit_test;
    import bmp_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_BYTES   = 205;
    localparam int N_PHASES      = 8;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_EVENT
    } t_row_mode;

    typedef struct {
        logic [7:0]  pbyte;
        bit          first;
        bit          last;
        t_row_mode   mode;
        logic [3:0]  kind;
        logic [3:0]  chan;
        logic [12:0] stamp;
        logic [1:0]  err;
    } t_row;

    typedef struct {
        t_beat     beat;
        t_row_mode mode;
        t_result   fixed_ev;
    } t_stim;

    // Directed packets, parsed with every event kind enabled.
    t_row directed_rows [30] = '{
        '{8'h00, 1'b0, 1'b0, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b1, 1'b1, ROW_EVENT,   KIND_ERROR, 4'h0, 13'h0, ERR_SHORT},
        '{8'h00, 1'b1, 1'b0, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b0, 1'b1, ROW_EVENT,   KIND_ERROR, 4'h0, 13'h0, ERR_SHORT},
        '{8'h00, 1'b1, 1'b0, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b0, 1'b0, ROW_EVENT,   KIND_ERROR, 4'h0, 13'h0, ERR_BAD_HEADER},
        '{8'h12, 1'b0, 1'b1, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b1, 1'b0, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b0, 1'b0, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h05, 1'b0, 1'b0, ROW_EVENT,   KIND_ERROR, 4'h0, 13'h0, ERR_NO_STATUS},
        '{8'h00, 1'b0, 1'b1, ROW_NONE,    4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hFF, 1'b1, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hE5, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h80, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hFC, 1'b0, 1'b0, ROW_EVENT,   KIND_STOP, STOP_CHANNEL, 13'h1F80, ERR_NONE},
        '{8'h81, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h01, 1'b0, 1'b0, ROW_EVENT,   KIND_STOP, STOP_CHANNEL, 13'h1F81, ERR_NONE},
        '{8'h02, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h82, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h93, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h3C, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h64, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h83, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'hA0, 1'b0, 1'b0, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE},
        '{8'h40, 1'b0, 1'b1, ROW_PREDICT, 4'h0, 4'h0, 13'h0, ERR_NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pkt_byte = 8'h00;
    logic        pkt_first = 1'b0;
    logic        pkt_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  ev_kind;
    logic [3:0]  ev_chan;
    logic [7:0]  ev_d1;
    logic [7:0]  ev_d2;
    logic [13:0] ev_bend;
    logic [12:0] ev_stamp;
    logic [1:0]  ev_err;

    // Predictor state
    t_phase      parse_state = PH_IDLE;
    logic [7:0]  run_status = 8'h00;
    logic [12:0] stamp_acc = 13'h0;
    logic [7:0]  held_byte = 8'h00;
    logic [7:0]  kind_enable = 8'h00;

    t_stim       stim_q [$];
    t_result     event_q [$];
    t_stim       offered;
    t_result     pred_ev;
    t_result     got_ev;
    t_result     want_ev;
    bit          pred_hit;
    bit          send_gappy = 1'b0;
    bit          recv_gappy = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          fail_count = 0;

    ble_midi_packet_parser_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_packet_byte  (pkt_byte),
        .i_packet_first (pkt_first),
        .i_packet_last  (pkt_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_event_kind   (ev_kind),
        .o_midi_channel (ev_chan),
        .o_data_first   (ev_d1),
        .o_data_second  (ev_d2),
        .o_bend_value   (ev_bend),
        .o_time_stamp   (ev_stamp),
        .o_error_code   (ev_err)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit emit_event(input logic [3:0] kind, input logic [3:0] chan,
                                      input logic [7:0] d1, input logic [7:0] d2,
                                      input logic [13:0] bend, input logic [12:0] stamp,
                                      input logic [1:0] err, output t_result ev);
        ev = '0;
        if (!kind[3] && !kind_enable[kind[2:0]]) return 1'b0;
        ev.event_kind   = kind;
        ev.midi_channel = chan;
        ev.data_first   = d1;
        ev.data_second  = d2;
        ev.bend_value   = bend;
        ev.time_stamp   = stamp;
        ev.error_code   = err;
        return 1'b1;
    endfunction

    function automatic bit flag_error(input logic [1:0] code, output t_result ev);
        parse_state = PH_SKIP;
        return emit_event(KIND_ERROR, 4'h0, 8'h00, 8'h00, 14'h0, 13'h0, code, ev);
    endfunction

    // First data byte of a channel message; program and channel pressure end here.
    function automatic bit take_first(input logic [7:0] b, output t_result ev);
        logic [3:0] cmd;
        cmd = run_status[7:4];
        ev = '0;
        if (cmd == CMD_PROGRAM || cmd == CMD_CHAN_PRS) begin
            parse_state = PH_LOOP;
            return emit_event({1'b0, cmd[2:0]}, run_status[3:0], b, 8'h00, 14'h0,
                              stamp_acc, ERR_NONE, ev);
        end
        held_byte = b;
        parse_state = PH_NEED_D2;
        return 1'b0;
    endfunction

    // A data byte where a message would begin, taken under the running status.
    function automatic bit start_data(input logic [7:0] b, input bit after_ts,
                                      output t_result ev);
        ev = '0;
        if (!run_status[7]) return flag_error(ERR_NO_STATUS, ev);
        if (run_status[7:4] == CMD_SYSTEM) begin
            parse_state = PH_LOOP;
            if (after_ts && run_status == STATUS_STOP)
                return emit_event(KIND_STOP, STOP_CHANNEL, 8'h00, 8'h00, 14'h0,
                                  stamp_acc, ERR_NONE, ev);
            return 1'b0;
        end
        return take_first(b, ev);
    endfunction

    function automatic bit decode_byte(input t_beat bt, output t_result ev);
        logic [7:0]  b;
        logic [3:0]  cmd;
        logic [13:0] bend;
        bit          hit;
        b = bt.packet_byte;
        hit = 1'b0;
        ev = '0;
        if (bt.packet_first) begin
            run_status = 8'h00;
            held_byte = b;
            stamp_acc = {b[5:0], 7'd0};
            parse_state = PH_TS1;
            if (bt.packet_last) begin
                hit = flag_error(ERR_SHORT, ev);
                parse_state = PH_IDLE;
            end
            return hit;
        end
        if (parse_state == PH_IDLE) return 1'b0;
        case (parse_state)
            PH_TS1: begin
                if (bt.packet_last) begin
                    hit = flag_error(ERR_SHORT, ev);
                end else if (!held_byte[7] || !b[7]) begin
                    hit = flag_error(ERR_BAD_HEADER, ev);
                end else begin
                    stamp_acc[6:0] = b[6:0];
                    parse_state = PH_AFTER_TS;
                end
            end
            PH_LOOP: begin
                if (b[7]) begin
                    stamp_acc[6:0] = b[6:0];
                    parse_state = PH_AFTER_TS;
                end else begin
                    hit = start_data(b, 1'b0, ev);
                end
            end
            PH_AFTER_TS: begin
                if (b[7]) begin
                    run_status = b;
                    if (b[7:4] == CMD_SYSTEM) begin
                        parse_state = PH_LOOP;
                        if (b == STATUS_STOP)
                            hit = emit_event(KIND_STOP, STOP_CHANNEL, 8'h00, 8'h00, 14'h0,
                                             stamp_acc, ERR_NONE, ev);
                    end else begin
                        parse_state = PH_NEED_D1;
                    end
                end else begin
                    hit = start_data(b, 1'b1, ev);
                end
            end
            PH_NEED_D1: hit = take_first(b, ev);
            PH_NEED_D2: begin
                cmd = run_status[7:4];
                bend = (cmd == CMD_BEND) ? {b[6:0], held_byte[6:0]} : 14'h0;
                parse_state = PH_LOOP;
                if (cmd[3])
                    hit = emit_event({1'b0, cmd[2:0]}, run_status[3:0], held_byte, b, bend,
                                     stamp_acc, ERR_NONE, ev);
            end
            default: ;
        endcase
        if (bt.packet_last) parse_state = PH_IDLE;
        return hit;
    endfunction

    function automatic int pick_gap(input bit gappy);
        int r;
        if (!gappy) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void log_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endfunction

    // Data bytes of one message; raw_first lets the first byte carry bit 7.
    function automatic void add_data(ref logic [7:0] pk [$], input logic [7:0] st,
                                     input bit raw_first);
        logic [31:0] r;
        int          n;
        case (st[7:4])
            CMD_PROGRAM, CMD_CHAN_PRS: n = 1;
            CMD_SYSTEM:                n = $urandom_range(0, 2);
            default:                   n = 2;
        endcase
        for (int i = 0; i < n; i++) begin
            r = $urandom();
            if (st[7:4] != CMD_SYSTEM && (i == 1 || raw_first) && r[31:28] < 4'd3)
                pk.push_back(r[7:0]);
            else
                pk.push_back({1'b0, r[6:0]});
        end
    endfunction

    // Builds one packet, mostly well formed, and queues its beats.
    task automatic queue_packet(output int n_bytes);
        logic [7:0]  pk [$];
        logic [7:0]  st;
        logic [31:0] r;
        t_stim       s;
        int          shape;
        int          tail;
        bit          has_status;
        bit          restart;
        shape = $urandom_range(0, 99);
        has_status = 1'b0;
        restart = 1'b0;
        st = 8'h00;
        r = $urandom();
        if (shape < 4) begin
            // A stray beat, outside a packet unless the last one was left open.
            s.beat.packet_byte = r[7:0];
            s.beat.packet_first = 1'b0;
            s.beat.packet_last = r[8];
            s.mode = ROW_PREDICT;
            s.fixed_ev = '0;
            stim_q.push_back(s);
            n_bytes = 1;
            return;
        end
        pk.push_back((r[31:27] == 5'd0) ? r[7:0] : {2'b10, r[5:0]});
        if (shape < 8) begin
        end else if (shape < 12) begin
            r = $urandom();
            pk.push_back(r[7:0]);
        end else if (shape < 18) begin
            repeat ($urandom_range(2, 8)) begin
                r = $urandom();
                pk.push_back(r[7:0]);
            end
        end else begin
            r = $urandom();
            pk.push_back((r[31:27] == 5'd0) ? r[7:0] : {1'b1, r[6:0]});
            repeat ($urandom_range(1, 5)) begin
                r = $urandom();
                if (!has_status || r[31:25] < 7'd70) begin
                    pk.push_back({1'b1, r[6:0]});
                    if (r[24:18] < (has_status ? 7'd100 : 7'd122)) begin
                        r = $urandom();
                        if (r[31:25] < 7'd108)
                            st = {r[3:0] % 4'd7 + 4'd8, r[7:4]};
                        else if (r[31:25] < 7'd120)
                            st = STATUS_STOP;
                        else
                            st = {CMD_SYSTEM, r[11:8]};
                        pk.push_back(st);
                        has_status = 1'b1;
                        add_data(pk, st, 1'b1);
                    end else begin
                        add_data(pk, st, 1'b0);
                    end
                end else begin
                    add_data(pk, st, 1'b0);
                end
            end
            r = $urandom();
            if (r[6:0] < 7'd12) begin
                tail = $urandom_range(1, 2);
                while (tail > 0 && pk.size() > 2) begin
                    void'(pk.pop_back());
                    tail--;
                end
            end else if (r[6:0] < 7'd16) begin
                pk.push_back({1'b1, r[30:24]});
            end else if (r[6:0] < 7'd20) begin
                restart = 1'b1;
            end
        end
        foreach (pk[i]) begin
            s.beat.packet_byte = pk[i];
            s.beat.packet_first = (i == 0);
            s.beat.packet_last = (i == pk.size() - 1) && !restart;
            s.mode = ROW_PREDICT;
            s.fixed_ev = '0;
            stim_q.push_back(s);
        end
        n_bytes = pk.size();
    endtask

    task automatic write_mask(input logic [7:0] m);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        kind_enable = m;
    endtask

    // Waits until every queued beat is taken and every expected event has come.
    // The check runs on the falling edge, once the rising-edge updates have settled.
    task automatic drain();
        while (stim_q.size() != 0 || in_valid || event_q.size() != 0 || out_valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: offers queued beats and predicts each one as it is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                pred_hit = decode_byte(offered.beat, pred_ev);
                if (offered.mode != ROW_PREDICT) begin
                    pred_hit = (offered.mode == ROW_EVENT);
                    pred_ev = offered.fixed_ev;
                end
                if (pred_hit) event_q.push_back(pred_ev);
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    offered = stim_q.pop_front();
                    pkt_byte <= offered.beat.packet_byte;
                    pkt_first <= offered.beat.packet_first;
                    pkt_last <= offered.beat.packet_last;
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_gappy);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each event beat against the oldest expectation.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            got_ev = {ev_kind, ev_chan, ev_d1, ev_d2, ev_bend, ev_stamp, ev_err};
            if (event_q.size() == 0) begin
                log_failure($sformatf("unexpected event: kind %0d ch %0d d %02h %02h err %0d",
                                      ev_kind, ev_chan, ev_d1, ev_d2, ev_err));
            end else begin
                want_ev = event_q.pop_front();
                if (got_ev !== want_ev)
                    log_failure($sformatf({"event mismatch: expected kind %0d ch %0d d %02h %02h",
                        " bend %0d ts %0d err %0d, got kind %0d ch %0d d %02h %02h",
                        " bend %0d ts %0d err %0d"},
                        want_ev.event_kind, want_ev.midi_channel, want_ev.data_first,
                        want_ev.data_second, want_ev.bend_value, want_ev.time_stamp,
                        want_ev.error_code, ev_kind, ev_chan, ev_d1, ev_d2, ev_bend,
                        ev_stamp, ev_err));
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            // One long hold-off so that the block fills and stalls its input.
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            recv_gap = pick_gap(recv_gappy);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_stim       s;
        logic [7:0]  m;
        int          queued;
        int          n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mask(8'hFF);
        foreach (directed_rows[i]) begin
            s.beat.packet_byte = directed_rows[i].pbyte;
            s.beat.packet_first = directed_rows[i].first;
            s.beat.packet_last = directed_rows[i].last;
            s.mode = directed_rows[i].mode;
            s.fixed_ev = '0;
            s.fixed_ev.event_kind = directed_rows[i].kind;
            s.fixed_ev.midi_channel = directed_rows[i].chan;
            s.fixed_ev.time_stamp = directed_rows[i].stamp;
            s.fixed_ev.error_code = directed_rows[i].err;
            stim_q.push_back(s);
        end
        drain();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       m = 8'h00;
                1:       m = 8'hFF;
                2:       m = 8'h01;
                3:       m = 8'h80;
                default: m = $urandom_range(0, 255);
            endcase
            write_mask(m);
            send_gappy = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            recv_gappy = $urandom_range(0, 3) != 0;
            if (phase == 1) hold_req = 1'b1;
            queued = 0;
            while (queued < PHASE_BYTES) begin
                queue_packet(n);
                queued += n;
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
src/bmp_pkg.sv
src/bmp_in_reg.sv
src/bmp_parse.sv
src/bmp_out_reg.sv
src/ble_midi_packet_parser_unit.sv
test/ble_midi_packet_parser_unit_test.sv
